// ----- rtl/core/aljce_pkg.sv -----
// shared types, constants and helpers of the chain energy block
`default_nettype none
package aljce_pkg;
	localparam int FracBitsDefault = 16;
	localparam logic [63:0] TermMax = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TermMin = 64'h8000_0000_0000_0000;
	localparam logic [31:0] CoefReset = 32'h0001_0000;

	// register addresses (word index)
	localparam logic [1:0] RegA1 = 2'd0;
	localparam logic [1:0] RegB1 = 2'd1;
	localparam logic [1:0] RegA2 = 2'd2;
	localparam logic [1:0] RegB2 = 2'd3;

	// coefficient set handed to the term unit
	typedef struct packed {
		logic signed [31:0] ca;
		logic signed [31:0] cb;
	} coef_pair_t;

	// saturating signed 64-bit add
	function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] s;
		begin
			s = x + y;
			if (!x[63] && !y[63] && s[63]) sat_add = TermMax;
			else if (x[63] && y[63] && !s[63]) sat_add = TermMin;
			else sat_add = s;
		end
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/aljce_if.sv -----
// valid/ready channel interfaces of the chain energy block
`default_nettype none
interface aljce_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_a;
	logic signed [31:0] pos_b;
	logic last_cell;
	modport source(output valid, pos_a, pos_b, last_cell, input ready);
	modport sink(input valid, pos_a, pos_b, last_cell, output ready);
endinterface

interface aljce_out_if;
	logic valid;
	logic ready;
	logic signed [63:0] energy;
	modport source(output valid, energy, input ready);
	modport sink(input valid, energy, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/alternating_lj_chain_energy_top.sv -----
// top level: lennard-jones chain energy accumulator with apb coefficients
// one word runs an intra term and, with a bond to the previous cell, a bond term;
// each term runs the serial divider, then the multiplier, then a handoff state
// a zero distance skips divider and multiplier; no new word while a cell is at work
// reset clears sums, previous position and restores all coefficients to 1.0
`default_nettype none
module alternating_lj_chain_energy_top
	import aljce_pkg::*;
#(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	aljce_in_if.sink         in_ch,
	aljce_out_if.source      out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam logic [1:0] St_Idle  = 2'd0;
	localparam logic [1:0] St_Intra = 2'd1;
	localparam logic [1:0] St_Bond  = 2'd2;
	localparam logic [1:0] St_Out   = 2'd3;

	logic [31:0] a1_q, b1_q, a2_q, b2_q;
	logic [1:0]  state_q;
	logic [31:0] pa_q, pb_q, prev_q;
	logic        last_q, have_prev_q, started_q;
	logic [63:0] sum_q;
	logic        ovalid_q;
	logic [63:0] oenergy_q;

	// register file
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[3:2])
			RegA1: prdata = a1_q;
			RegB1: prdata = b1_q;
			RegA2: prdata = a2_q;
			default: prdata = b2_q;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1_q <= CoefReset; b1_q <= CoefReset;
			a2_q <= CoefReset; b2_q <= CoefReset;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				RegA1: a1_q <= pwdata;
				RegB1: b1_q <= pwdata;
				RegA2: a2_q <= pwdata;
				default: b2_q <= pwdata;
			endcase
		end
	end

	// term unit hookup
	logic tstart, tdone;
	logic [32:0] tdist;
	coef_pair_t tcoef;
	logic [63:0] tval;
	assign tstart = (state_q == St_Intra || state_q == St_Bond) && !started_q;
	always_comb begin
		if (state_q == St_Bond) begin
			tdist = {pa_q[31], pa_q} - {prev_q[31], prev_q};
			tcoef.ca = a2_q; tcoef.cb = b2_q;
		end else begin
			tdist = {pb_q[31], pb_q} - {pa_q[31], pa_q};
			tcoef.ca = a1_q; tcoef.cb = b1_q;
		end
	end
	aljce_term #(.FRAC_BITS(FRAC_BITS)) u_term (
		.clk(clk), .arst_n(arst_n), .start(tstart), .delta(tdist),
		.coef(tcoef), .done(tdone), .term(tval)
	);

	assign in_ch.ready = (state_q == St_Idle) && !(ovalid_q && last_q);
	assign out_ch.valid = ovalid_q;
	assign out_ch.energy = oenergy_q;

	// cell sequencer
	logic [63:0] sum_n;
	assign sum_n = sat_add(sum_q, tval);
	// result register takes a new word when free or draining
	logic load_out;
	assign load_out = (state_q == St_Out) && last_q && (!ovalid_q || out_ch.ready);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= St_Idle;
			started_q <= 1'b0;
			have_prev_q <= 1'b0;
			sum_q <= '0;
			prev_q <= '0;
			last_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (load_out) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				St_Idle: begin
					if (in_ch.valid && in_ch.ready) begin
						pa_q <= in_ch.pos_a; pb_q <= in_ch.pos_b;
						last_q <= in_ch.last_cell;
						state_q <= St_Intra;
					end
				end
				St_Intra, St_Bond: begin
					if (tstart) started_q <= 1'b1;
					if (tdone) begin
						sum_q <= sum_n;
						started_q <= 1'b0;
						if (state_q == St_Intra && have_prev_q) state_q <= St_Bond;
						else state_q <= St_Out;
					end
				end
				default: begin
					if (!ovalid_q || out_ch.ready || !last_q) begin
						if (last_q) begin
							oenergy_q <= sum_q;
							sum_q <= '0;
							prev_q <= '0;
							have_prev_q <= 1'b0;
						end else begin
							prev_q <= pb_q;
							have_prev_q <= 1'b1;
						end
						last_q <= 1'b0;
						state_q <= St_Idle;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/aljce_term.sv -----
// one lennard-jones term on a shared serial divider and 32x32 multiplier
`default_nettype none
module aljce_term
	import aljce_pkg::*;
#(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] delta,
	input  wire coef_pair_t  coef,
	output logic             done,
	output logic [63:0]      term
);
	localparam int NumW = 33 + FRAC_BITS;

	localparam logic [3:0] St_Idle = 4'd0;
	localparam logic [3:0] St_Div  = 4'd1;
	localparam logic [3:0] St_Mul  = 4'd2;
	localparam logic [3:0] St_Done = 4'd3;

	// product program steps
	localparam logic [2:0] Op_U2  = 3'd0;
	localparam logic [2:0] Op_U3  = 3'd1;
	localparam logic [2:0] Op_S6  = 3'd2;
	localparam logic [2:0] Op_S12 = 3'd3;
	localparam logic [2:0] Op_CA  = 3'd4;
	localparam logic [2:0] Op_CB  = 3'd5;

	logic [3:0]  state_q;
	logic [32:0] mag_q;
	logic [NumW-1:0] rem_q;
	logic [NumW-1:0] quo_q;
	logic [6:0]  cnt_q;
	logic [2:0]  op_q;
	logic [1:0]  part_q;
	logic [63:0] x_q, y_q, t_q, s6_q, pa_q;
	logic [127:0] acc_q;
	logic        lim_q;
	coef_pair_t  coef_q;

	// magnitude of the distance
	logic [32:0] dmag;
	assign dmag = delta[32] ? (~delta + 33'd1) : delta;

	// restoring division step on 2^(32+F) / mag
	logic [NumW:0] trial;
	assign trial = {rem_q, quo_q[NumW-1]} - {{(NumW-32){1'b0}}, mag_q};

	// reciprocal widened to q32.32
	logic [63:0] u_val;
	assign u_val = {{(64-NumW){1'b0}}, quo_q};

	// one 32x32 partial product per cycle
	logic [31:0] xa, yb;
	logic [63:0] pp;
	assign xa = part_q[0] ? x_q[63:32] : x_q[31:0];
	assign yb = part_q[1] ? y_q[63:32] : y_q[31:0];
	assign pp = xa * yb;
	logic [6:0] sh;
	assign sh = {part_q[1] & part_q[0], part_q[1] ^ part_q[0], 5'd0};
	logic [127:0] acc_n;
	assign acc_n = acc_q + ({64'd0, pp} << sh);

	// unsigned q32.32 product, clamped
	logic [63:0] uq;
	assign uq = (acc_n[127:95] != '0) ? TermMax : acc_n[95:32];
	// coefficient scale magnitude, clamped
	logic [63:0] cs;
	assign cs = (acc_n[127:64+FRAC_BITS] != '0 || acc_n[63+FRAC_BITS] == 1'b1)
		? TermMax : acc_n[63+FRAC_BITS:FRAC_BITS];
	logic [31:0] cmag_a, cmag_b;
	assign cmag_a = coef_q.ca[31] ? (~coef_q.ca + 32'd1) : coef_q.ca;
	assign cmag_b = coef_q.cb[31] ? (~coef_q.cb + 32'd1) : coef_q.cb;

	// r-to-zero limit
	logic [63:0] lim_val;
	always_comb begin
		if (coef_q.ca != 0) lim_val = coef_q.ca[31] ? (~TermMax + 64'd1) : TermMax;
		else if (coef_q.cb != 0) lim_val = coef_q.cb[31] ? TermMax : (~TermMax + 64'd1);
		else lim_val = '0;
	end

	assign done = (state_q == St_Done);
	assign term = lim_q ? lim_val : t_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= St_Idle;
			cnt_q <= '0;
			op_q <= Op_U2;
			part_q <= '0;
			lim_q <= 1'b0;
		end else begin
			unique case (state_q)
				St_Idle: begin
					if (start) begin
						coef_q <= coef;
						mag_q <= dmag;
						rem_q <= '0;
						quo_q <= {1'b1, {(NumW-1){1'b0}}};
						cnt_q <= 7'(NumW);
						lim_q <= (dmag == '0);
						state_q <= (dmag == '0) ? St_Done : St_Div;
					end
				end
				St_Div: begin
					if (!trial[NumW]) begin
						rem_q <= trial[NumW-1:0];
						quo_q <= {quo_q[NumW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[NumW-2:0], quo_q[NumW-1]};
						quo_q <= {quo_q[NumW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						state_q <= St_Mul;
						op_q <= Op_U2;
						part_q <= '0;
						acc_q <= '0;
					end
				end
				St_Mul: begin
					if (op_q == Op_U2 && part_q == 2'd0 && acc_q == '0 && cnt_q == 7'd0) begin
						x_q <= u_val;
						y_q <= u_val;
						t_q <= '0;
						cnt_q <= 7'd1;
					end else begin
						acc_q <= acc_n;
						part_q <= part_q + 2'd1;
						if (part_q == 2'd3) begin
							acc_q <= '0;
							unique case (op_q)
								Op_U2: begin
									x_q <= uq; y_q <= u_val; op_q <= Op_U3;
								end
								Op_U3: begin
									x_q <= uq; y_q <= uq; op_q <= Op_S6;
								end
								Op_S6: begin
									s6_q <= uq; x_q <= uq; y_q <= uq; op_q <= Op_S12;
								end
								Op_S12: begin
									if (uq == TermMax) begin
										lim_q <= 1'b1;
										state_q <= St_Done;
									end
									x_q <= {32'd0, cmag_a}; y_q <= uq; op_q <= Op_CA;
								end
								Op_CA: begin
									pa_q <= coef_q.ca[31] ? (~cs + 64'd1) : cs;
									x_q <= {32'd0, cmag_b}; y_q <= s6_q; op_q <= Op_CB;
								end
								default: begin
									t_q <= sat_add(pa_q, coef_q.cb[31] ? cs : (~cs + 64'd1));
									state_q <= St_Done;
								end
							endcase
						end
					end
				end
				default: begin
					state_q <= St_Idle;
					cnt_q <= '0;
					lim_q <= 1'b0;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/aljce_checker.sv -----
// port-level checker bound to the chain energy top level
`default_nettype none
module aljce_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] energy,
	input wire logic        pready
);
	// apb never stalls
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	// held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(energy))
		else $error("result changed while stalled");
	// an accepted cell keeps the block busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");
	// a result only appears after the block was busy
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without work");
endmodule

bind alternating_lj_chain_energy_top aljce_props u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .energy(out_ch.energy),
	.pready(pready)
);
`default_nettype wire
